// ----- design/timestamp_batch_issuer_core_macros.svh -----
// Assertion shorthands used by the checker file.
`ifndef TIMESTAMP_BATCH_ISSUER_CORE_MACROS_SVH
`define TIMESTAMP_BATCH_ISSUER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet while rst_n is low.
`define TBI_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("timestamp batch issuer: same-cycle check failed");

// Next-cycle implication, sampled on clk, quiet while rst_n is low.
`define TBI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("timestamp batch issuer: next-cycle check failed");

`endif

// ----- design/tbi_pkg.sv -----
package tbi_pkg;

    // Field widths
    localparam int unsigned TIME_W   = 64;
    localparam int unsigned BATCH_W  = 16;
    localparam int unsigned STEP_W   = 10;
    localparam int unsigned STATUS_W = 2;

    // Nanoseconds in one microsecond
    localparam int unsigned NS_PER_US = 1000;

    // Per-microsecond cap is 1000 / step, at most 1000
    localparam int unsigned CAP_W     = 10;
    localparam int unsigned CAP_STEPS = CAP_W;

    // Remainder mod 1000, reduced one 4-bit digit per cycle
    localparam int unsigned MOD_W       = 10;
    localparam int unsigned DIGIT_W     = 4;
    localparam int unsigned DIGIT_STEPS = TIME_W / DIGIT_W;
    localparam int unsigned CNT_W       = $clog2(DIGIT_STEPS);

    // Configuration port
    localparam int unsigned PADDR_W   = 6;
    localparam int unsigned PDATA_W   = 64;
    localparam int unsigned ADDR_LSB  = 3;
    localparam int unsigned REG_IDX_W = PADDR_W - ADDR_LSB;

    localparam logic [REG_IDX_W-1:0] REG_ISSUE_ENABLE     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_IGNORE_THRESHOLD = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_TIME_ADJUSTMENT  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_RESERVED_THRESH  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_STEP             = 3'd4;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_ISSUED    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOT_READY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RETRY     = 2'd2;

    typedef struct packed {
        logic [TIME_W-1:0]  now_ns;
        logic [BATCH_W-1:0] batch_wanted;
    } tbi_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [TIME_W-1:0]   batch_base;
        logic [BATCH_W-1:0]  batch_count;
    } tbi_rsp_t;

    typedef struct packed {
        logic              issue_enable;
        logic              ignore_threshold;
        logic [TIME_W-1:0] time_adjustment_ns;
        logic [TIME_W-1:0] reserved_threshold_ns;
        logic [STEP_W-1:0] step_ns;
    } tbi_cfg_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic mod_step;
        logic cap_step;
        logic sub;
        logic cmp;
        logic commit;
    } tbi_cmd_t;

endpackage

// ----- design/tbi_chan_if.sv -----
interface tbi_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- design/tbi_regs.sv -----
module tbi_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tbi_pkg::PADDR_W-1:0]  paddr,
    input  logic [tbi_pkg::PDATA_W-1:0]  pwdata,
    output logic [tbi_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output tbi_pkg::tbi_cfg_t            cfg
);
    import tbi_pkg::*;

    localparam logic [STEP_W-1:0] STEP_RESET = 10'd10;

    logic                 issue_enable_reg;
    logic                 ignore_threshold_reg;
    logic [TIME_W-1:0]    time_adjustment_reg;
    logic [TIME_W-1:0]    reserved_threshold_reg;
    logic [STEP_W-1:0]    step_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:ADDR_LSB];
    assign wr_en   = psel && penable && pwrite && pready;

    // Write registers on the access cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_enable_reg       <= 1'b0;
            ignore_threshold_reg   <= 1'b0;
            time_adjustment_reg    <= '0;
            reserved_threshold_reg <= '0;
            step_reg               <= STEP_RESET;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_ISSUE_ENABLE:     issue_enable_reg       <= pwdata[0];
                REG_IGNORE_THRESHOLD: ignore_threshold_reg   <= pwdata[0];
                REG_TIME_ADJUSTMENT:  time_adjustment_reg    <= pwdata;
                REG_RESERVED_THRESH:  reserved_threshold_reg <= pwdata;
                REG_STEP:             step_reg               <= pwdata[STEP_W-1:0];
                default:              ;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        case (reg_idx)
            REG_ISSUE_ENABLE:     prdata = PDATA_W'(issue_enable_reg);
            REG_IGNORE_THRESHOLD: prdata = PDATA_W'(ignore_threshold_reg);
            REG_TIME_ADJUSTMENT:  prdata = time_adjustment_reg;
            REG_RESERVED_THRESH:  prdata = reserved_threshold_reg;
            REG_STEP:             prdata = PDATA_W'(step_reg);
            default:              prdata = '0;
        endcase
    end

    assign cfg.issue_enable          = issue_enable_reg;
    assign cfg.ignore_threshold      = ignore_threshold_reg;
    assign cfg.time_adjustment_ns    = time_adjustment_reg;
    assign cfg.reserved_threshold_ns = reserved_threshold_reg;
    assign cfg.step_ns               = step_reg;

endmodule

// ----- design/tbi_ctrl.sv -----
module tbi_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output tbi_pkg::tbi_cmd_t cmd
);
    import tbi_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_SUB  = 3'd2;
    localparam logic [2:0] S_CMP  = 3'd3;
    localparam logic [2:0] S_DEC  = 3'd4;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIGIT_STEPS - 1);

    logic [2:0]       state_reg;
    logic [2:0]       state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // Sequence one item: load, digit loop, subtract, compare, decide
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;

        // drop the result once it is taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.mod_step = 1'b1;
                cmd.cap_step = (cnt_reg < CNT_W'(CAP_STEPS));
                cnt_next     = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = S_SUB;
                end
            end
            S_SUB:
            begin
                cmd.sub    = 1'b1;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                cmd.cmp    = 1'b1;
                state_next = S_DEC;
            end
            S_DEC:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- design/tbi_dp.sv -----
module tbi_dp #(
    parameter int unsigned CORE_INDEX = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  tbi_pkg::tbi_cmd_t cmd,
    input  tbi_pkg::tbi_cfg_t cfg,
    input  tbi_pkg::tbi_req_t req,
    output tbi_pkg::tbi_rsp_t rsp
);
    import tbi_pkg::*;

    localparam int unsigned DV_W = MOD_W + DIGIT_W;
    localparam int unsigned PROD_W = BATCH_W + STEP_W;
    localparam logic [TIME_W-1:0] BASE_OFFSET = TIME_W'(CORE_INDEX) - TIME_W'(1);

    // Working registers
    logic [TIME_W-1:0]       sum_reg;
    logic [TIME_W-1:0]       sh_reg;
    logic [BATCH_W-1:0]      wanted_reg;
    logic [MOD_W-1:0]        mod_reg;
    logic [CAP_W-1:0]        cap_rem_reg;
    logic [CAP_W-1:0]        cap_q_reg;
    logic [TIME_W-1:0]       cur_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic                    reached_reg;
    logic                    later_reg;
    logic                    earlier_reg;
    logic [TIME_W-1:0]       cur_off_reg;

    // Microsecond state
    logic [TIME_W-1:0]       last_us_reg;
    logic [BATCH_W-1:0]      issued_reg;

    // Result register
    logic [STATUS_W-1:0]     status_reg;
    logic [TIME_W-1:0]       base_reg;
    logic [BATCH_W-1:0]      count_reg;

    logic [STEP_W-1:0]       step_eff;
    logic [DV_W-1:0]         digit_val;
    logic [DV_W-1:0]         digit_red;
    logic [CAP_W:0]          cap_trial;
    logic                    cap_ge;
    logic [BATCH_W-1:0]      cap_wide;
    logic [BATCH_W-1:0]      new_count;
    logic [BATCH_W-1:0]      left;
    logic [STATUS_W-1:0]     status_next;
    logic [TIME_W-1:0]       base_next;
    logic [BATCH_W-1:0]      count_next;
    logic                    take_new;
    logic                    take_same;

    // A zero step acts as one
    assign step_eff = (cfg.step_ns == '0) ? STEP_W'(1) : cfg.step_ns;

    // Shift in one digit and reduce mod 1000
    always_comb
    begin
        digit_val = {mod_reg, {DIGIT_W{1'b0}}}
                    + DV_W'(sh_reg[TIME_W-1 -: DIGIT_W]);
        digit_red = digit_val;
        for (int k = 1; k < (1 << DIGIT_W); k++)
        begin
            if (digit_val >= DV_W'(k * NS_PER_US))
            begin
                digit_red = digit_val - DV_W'(k * NS_PER_US);
            end
        end
    end

    // One restoring step of 1000 / step
    assign cap_trial = {cap_rem_reg, cap_q_reg[CAP_W-1]};
    assign cap_ge    = (cap_trial >= {1'b0, step_eff});

    // Decide the result from registered compares
    always_comb
    begin
        cap_wide    = BATCH_W'(cap_q_reg);
        new_count   = (wanted_reg < cap_wide) ? wanted_reg : cap_wide;
        left        = (issued_reg > cap_wide) ? '0 : cap_wide - issued_reg;
        status_next = STATUS_NOT_READY;
        base_next   = '0;
        count_next  = '0;
        take_new    = 1'b0;
        take_same   = 1'b0;

        if (!cfg.issue_enable)
        begin
            status_next = STATUS_NOT_READY;
        end
        else if (!cfg.ignore_threshold && reached_reg)
        begin
            status_next = STATUS_NOT_READY;
        end
        else if (later_reg)
        begin
            status_next = STATUS_ISSUED;
            base_next   = cur_off_reg;
            count_next  = new_count;
            take_new    = 1'b1;
        end
        else if (earlier_reg)
        begin
            status_next = STATUS_NOT_READY;
        end
        else if (left < wanted_reg)
        begin
            status_next = STATUS_RETRY;
        end
        else
        begin
            status_next = STATUS_ISSUED;
            base_next   = cur_off_reg + TIME_W'(prod_reg);
            count_next  = wanted_reg;
            take_same   = 1'b1;
        end
    end

    // Working and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sum_reg     <= req.now_ns + cfg.time_adjustment_ns;
            sh_reg      <= req.now_ns + cfg.time_adjustment_ns;
            wanted_reg  <= req.batch_wanted;
            mod_reg     <= '0;
            cap_rem_reg <= '0;
            cap_q_reg   <= CAP_W'(NS_PER_US);
        end
        if (cmd.mod_step)
        begin
            mod_reg <= digit_red[MOD_W-1:0];
            sh_reg  <= {sh_reg[TIME_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
        end
        if (cmd.cap_step)
        begin
            cap_rem_reg <= cap_ge ? CAP_W'(cap_trial - {1'b0, step_eff})
                                  : cap_trial[CAP_W-1:0];
            cap_q_reg   <= {cap_q_reg[CAP_W-2:0], cap_ge};
        end
        if (cmd.sub)
        begin
            cur_reg  <= sum_reg - TIME_W'(mod_reg);
            prod_reg <= PROD_W'(issued_reg) * PROD_W'(step_eff);
        end
        if (cmd.cmp)
        begin
            // a sum past the top of the range counts as reached
            reached_reg <= ({1'b0, cur_reg} + (TIME_W + 1)'(NS_PER_US))
                           >= {1'b0, cfg.reserved_threshold_ns};
            later_reg   <= (cur_reg > last_us_reg);
            earlier_reg <= (cur_reg < last_us_reg);
            cur_off_reg <= cur_reg + BASE_OFFSET;
        end
        if (cmd.commit)
        begin
            status_reg <= status_next;
            base_reg   <= base_next;
            count_reg  <= count_next;
        end
    end

    // Advance the microsecond state on commit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_us_reg <= '0;
            issued_reg  <= '0;
        end
        else if (cmd.commit)
        begin
            if (take_new)
            begin
                last_us_reg <= cur_reg;
                issued_reg  <= new_count;
            end
            else if (take_same)
            begin
                issued_reg <= issued_reg + wanted_reg;
            end
        end
    end

    assign rsp.status      = status_reg;
    assign rsp.batch_base  = base_reg;
    assign rsp.batch_count = count_reg;

endmodule

// ----- design/timestamp_batch_issuer_core.sv -----
// Timestamp batch issuer. Each request item carries now_ns and batch_wanted;
// the block adds the adjustment register, rounds down to the microsecond and
// answers with one result item: status (issued, not ready, retry next
// microsecond), batch_base and batch_count. One item is worked at a time, in
// order: load, a digit loop in which the remainder mod 1000 is reduced one
// 4-bit digit per cycle (the 10-step divide of 1000 by step_ns runs
// alongside), then subtract, compare and decide. A finished result waits in
// an output register, so the next item is taken while it is still pending; a
// result that is not taken holds the block in its decide cycle. Configuration
// is to be written over the APB port at byte address 8*i only while no item is
// in work; the user is bound to this, the block does not enforce it.
module timestamp_batch_issuer_core #(
    parameter int unsigned CORE_INDEX = 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    tbi_chan_if.sink                    req,
    tbi_chan_if.source                  rsp,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tbi_pkg::PADDR_W-1:0] paddr,
    input  logic [tbi_pkg::PDATA_W-1:0] pwdata,
    output logic [tbi_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);
    import tbi_pkg::*;

    tbi_cfg_t cfg;
    tbi_cmd_t cmd;
    tbi_rsp_t rsp_data;
    tbi_req_t req_data;

    assign req_data    = req.payload;
    assign rsp.payload = rsp_data;

    tbi_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tbi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd)
    );

    tbi_dp #(
        .CORE_INDEX (CORE_INDEX)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .cfg   (cfg),
        .req   (req_data),
        .rsp   (rsp_data)
    );

endmodule

// ----- design/tbi_checker.sv -----
`include "timestamp_batch_issuer_core_macros.svh"

module tbi_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_ready,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic [tbi_pkg::STATUS_W-1:0]  rsp_status,
    input logic [tbi_pkg::TIME_W-1:0]    rsp_base,
    input logic [tbi_pkg::BATCH_W-1:0]   rsp_count
);
    import tbi_pkg::*;

    // A pending result stays offered
    `TBI_ASSERT_NEXT(a_rsp_held, rsp_valid && !rsp_ready, rsp_valid)

    // An accepted item occupies the block for the next cycle
    `TBI_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready)

    // A fresh result comes only out of the decide cycle, never from idle
    `TBI_ASSERT_NOW(a_rsp_from_work, $rose(rsp_valid), $past(!req_ready))

    // Refused items carry an empty batch
    `TBI_ASSERT_NOW(a_empty_refusal, rsp_valid && (rsp_status != STATUS_ISSUED),
        (rsp_count == '0) && (rsp_base == '0))

endmodule

bind timestamp_batch_issuer_core tbi_checker u_tbi_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_status (rsp.payload.status),
    .rsp_base   (rsp.payload.batch_base),
    .rsp_count  (rsp.payload.batch_count)
);
